FILE: src/k_way_sorted_merge_assert.svh
// assertion macros shared by the checker of the k-way merge block
// needs nothing else; each macro expands to one labelled concurrent assertion
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define KWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kwm assertion failed");

// consequent must hold in the cycle after the antecedent
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kwm assertion failed");

`endif

FILE: src/kwm_pkg.sv
// mode and status codes plus the result record of the k-way merge block
// no dependencies; used by the sequencer, the top level and the checker
package kwm_pkg;

	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_POP   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [2:0] ST_PUSHED  = 3'd0;
	localparam logic [2:0] ST_DROPPED = 3'd1;
	localparam logic [2:0] ST_POPPED  = 3'd2;
	localparam logic [2:0] ST_EMPTY   = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] value;
		logic [2:0]         list;
	} res_t;

endpackage

FILE: src/kwm_store.sv
// element memory of the k-way merge block: one write port, one read port
// read data is registered; no dependencies
module kwm_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic signed [31:0]   wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic signed [31:0]   rdata
);

	logic signed [31:0] mem [DEPTH];
	logic signed [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/kwm_ctrl.sv
// sequencer of the k-way merge block: head and tail positions, push, clear
// and the pop scan over the element memory; uses kwm_pkg
module kwm_ctrl #(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64,
	parameter int AW         = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         mode,
	input  logic [2:0]         list_id,
	input  logic signed [31:0] value,
	output logic               res_valid,
	output kwm_pkg::res_t      res,
	input  logic               out_free,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic signed [31:0] mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  logic signed [31:0] mem_rdata
);

	localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int PW = $clog2(2 * LIST_DEPTH);
	localparam int SW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [PW-1:0] POS_LAST = PW'(2 * LIST_DEPTH - 1);
	localparam logic [PW-1:0] DEPTH_P  = PW'(LIST_DEPTH);
	localparam logic [LW-1:0] K_LAST   = LW'(NUM_LISTS - 1);

	typedef enum logic [2:0] {
		IDLE,
		EXEC,
		SCAN,
		DRAIN,
		FIN,
		RESP
	} state_t;

	state_t             state_q;
	logic [1:0]         mode_q;
	logic [2:0]         id_q;
	logic signed [31:0] value_q;
	logic [PW-1:0]      head_q [NUM_LISTS];
	logic [PW-1:0]      tail_q [NUM_LISTS];
	logic [LW-1:0]      k_q;
	logic               pend_s1;
	logic [LW-1:0]      pk_s1;
	logic               found_q;
	logic signed [31:0] best_q;
	logic [LW-1:0]      bestk_q;
	kwm_pkg::res_t      res_q;

	logic [LW-1:0]      id_idx;
	logic [LW-1:0]      idx;
	logic [PW-1:0]      hsel;
	logic [PW-1:0]      tsel;
	logic [PW:0]        fill;
	logic               id_ok;
	logic               push_ok;
	logic               empty_sel;

	function automatic logic [SW-1:0] slot_of(input logic [PW-1:0] pos);
		logic [PW-1:0] adj;
		adj = (pos >= DEPTH_P) ? pos - DEPTH_P : pos;
		return SW'(adj);
	endfunction

	function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] pos);
		return (pos == POS_LAST) ? '0 : pos + PW'(1);
	endfunction

	assign id_idx    = LW'(id_q);
	assign idx       = (state_q == SCAN) ? k_q : id_idx;
	assign hsel      = head_q[idx];
	assign tsel      = tail_q[idx];
	assign empty_sel = (hsel == tsel);
	// positions run modulo twice the depth, so full and empty differ
	assign fill      = {1'b0, tsel} - {1'b0, hsel}
	                 + ((tsel < hsel) ? (PW+1)'(2 * LIST_DEPTH) : '0);
	assign id_ok     = int'(id_q) < NUM_LISTS;
	assign push_ok   = id_ok && (fill < (PW+1)'(LIST_DEPTH));

	assign mem_we    = (state_q == EXEC) && (mode_q == kwm_pkg::MODE_PUSH) && push_ok;
	assign mem_waddr = AW'(idx) * AW'(LIST_DEPTH) + AW'(slot_of(tsel));
	assign mem_wdata = value_q;
	assign mem_re    = (state_q == SCAN) && !empty_sel;
	assign mem_raddr = AW'(idx) * AW'(LIST_DEPTH) + AW'(slot_of(hsel));

	assign item_stall = (state_q != IDLE);
	assign res_valid  = (state_q == RESP);
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			mode_q  <= '0;
			id_q    <= '0;
			value_q <= '0;
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			k_q     <= '0;
			pend_s1 <= 1'b0;
			pk_s1   <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			bestk_q <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (item_valid) begin
						mode_q  <= mode;
						id_q    <= list_id;
						value_q <= value;
						state_q <= EXEC;
					end
				end
				EXEC: begin
					res_q   <= '0;
					state_q <= RESP;
					case (mode_q)
						kwm_pkg::MODE_PUSH: begin
							if (push_ok) begin
								for (int i = 0; i < NUM_LISTS; i++) begin
									if (LW'(i) == id_idx) begin
										tail_q[i] <= pos_inc(tail_q[i]);
									end
								end
								res_q.status <= kwm_pkg::ST_PUSHED;
							end else begin
								res_q.status <= kwm_pkg::ST_DROPPED;
							end
						end
						kwm_pkg::MODE_POP: begin
							k_q     <= '0;
							found_q <= 1'b0;
							state_q <= SCAN;
						end
						kwm_pkg::MODE_CLEAR: begin
							for (int i = 0; i < NUM_LISTS; i++) begin
								head_q[i] <= '0;
								tail_q[i] <= '0;
							end
							res_q.status <= kwm_pkg::ST_CLEARED;
						end
						default: begin
							res_q.status <= kwm_pkg::ST_EMPTY;
						end
					endcase
				end
				SCAN: begin
					if (k_q == K_LAST) begin
						state_q <= DRAIN;
					end else begin
						k_q <= k_q + LW'(1);
					end
				end
				DRAIN: begin
					state_q <= FIN;
				end
				FIN: begin
					if (found_q) begin
						for (int i = 0; i < NUM_LISTS; i++) begin
							if (LW'(i) == bestk_q) begin
								head_q[i] <= pos_inc(head_q[i]);
							end
						end
						res_q.status <= kwm_pkg::ST_POPPED;
						res_q.value  <= best_q;
						res_q.list   <= 3'(bestk_q);
					end else begin
						res_q <= '0;
						res_q.status <= kwm_pkg::ST_EMPTY;
					end
					state_q <= RESP;
				end
				RESP: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase

			// head read lands in the cycle after issue; ties go to the later list
			pend_s1 <= mem_re;
			pk_s1   <= k_q;
			if (pend_s1 && (!found_q || (mem_rdata <= best_q))) begin
				found_q <= 1'b1;
				best_q  <= mem_rdata;
				bestk_q <= pk_s1;
			end
		end
	end

endmodule

FILE: src/k_way_sorted_merge.sv
// Merges up to NUM_LISTS ascending lists, each a ring of LIST_DEPTH signed
// 32-bit entries in one synchronous element memory, and answers every request
// with one result. A push or a clear passes EXEC and RESP on its way to the
// result register; a pop also passes SCAN, DRAIN and FIN, as the heads are
// read from the element memory one list a cycle through its single read port
// and compared as they arrive, equal heads going to the higher list. One
// request is in work at a time; item_stall stays high from acceptance until
// the result has moved into the output register, which frees the sequencer
// while a result waits on result_stall. No clearing pass follows reset.
module k_way_sorted_merge #(
	parameter int NUM_LISTS  = 8,
	parameter int LIST_DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         mode,
	input  logic [2:0]         list_id,
	input  logic signed [31:0] value,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         status,
	output logic signed [31:0] out_value,
	output logic [2:0]         out_list
);

	localparam int DEPTH = NUM_LISTS * LIST_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic               res_valid;
	kwm_pkg::res_t      res;
	logic               out_free;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic signed [31:0] mem_rdata;
	logic               result_valid_q;
	kwm_pkg::res_t      out_q;

	kwm_ctrl #(
		.NUM_LISTS  (NUM_LISTS),
		.LIST_DEPTH (LIST_DEPTH),
		.AW         (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.list_id    (list_id),
		.value      (value),
		.res_valid  (res_valid),
		.res        (res),
		.out_free   (out_free),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	kwm_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register frees once its result is taken
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			out_q          <= '0;
		end else begin
			if (res_valid && out_free) begin
				result_valid_q <= 1'b1;
				out_q          <= res;
			end else if (out_free) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign status       = out_q.status;
	assign out_value    = out_q.value;
	assign out_list     = out_q.list;

endmodule

FILE: src/kwm_checker.sv
// port-level checks for the k-way merge block, attached by bind
// uses kwm_pkg and the macros of k_way_sorted_merge_assert.svh
`include "k_way_sorted_merge_assert.svh"

module kwm_props (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic [2:0]         status,
	input logic signed [31:0] out_value,
	input logic [2:0]         out_list
);

	logic [37:0] res_word;
	logic        not_pop;
	logic        idle_fields;

	assign res_word    = {status, out_value, out_list};
	assign not_pop     = result_valid && (status != kwm_pkg::ST_POPPED);
	assign idle_fields = (out_value == 32'sd0) && (out_list == 3'd0);

	// a held result keeps its payload
	`KWM_ASSERT_NEXT(a_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(res_word))

	// only a successful pop carries a value and a list
	`KWM_ASSERT_NOW(a_zero, clk, arst_n, not_pop, idle_fields)

	`KWM_ASSERT_NOW(a_code, clk, arst_n, result_valid, status <= kwm_pkg::ST_CLEARED)

	// one request at a time: busy right after acceptance
	`KWM_ASSERT_NEXT(a_busy, clk, arst_n, item_valid && !item_stall, item_stall)

endmodule

bind k_way_sorted_merge kwm_props u_kwm_props (.*);
